// ----- rtl/core/b62_pkg.sv -----
// ----------------------------------------------------------------------------
// b62_pkg: shared types, codes and character helpers of the base-62 codec.
// Holds the request and response payload types and the glyph mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b62_pkg;

   localparam int unsigned MAX_DIGITS_DEF = 11;
   localparam int unsigned BASE           = 62;
   localparam int unsigned NUM_W          = 63;
   // The dividend is walked in 6-bit chunks, most significant chunk first.
   localparam int unsigned CHUNK_W        = 6;
   localparam int unsigned NUM_CHUNKS     = (NUM_W + CHUNK_W - 1) / CHUNK_W;
   localparam int unsigned DIVD_W         = NUM_CHUNKS * CHUNK_W;
   localparam int unsigned CHUNK_CNT_W    = $clog2(NUM_CHUNKS);

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic KIND_DIGIT  = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic             operation;
      logic [NUM_W-1:0] number;
      logic [7:0]       code_char;
      logic             end_of_code;
   } req_type;

   typedef struct packed {
      logic [7:0]       digit_char;
      logic             last_digit;
      logic [NUM_W-1:0] decoded_value;
      logic [1:0]       status;
      logic             result_kind;
   } rsp_type;

   // Digit value 0..61 to its character.
   function automatic logic [7:0] digit_to_glyph(input logic [5:0] d);
      logic [7:0] g;
      if (d < 6'd10) begin
         g = 8'h30 + {2'b00, d};
      end else if (d < 6'd36) begin
         g = 8'h41 + {2'b00, d} - 8'd10;
      end else begin
         g = 8'h61 + {2'b00, d} - 8'd36;
      end
      return g;
   endfunction

   // Character to digit value; bit 6 set means the byte is outside the alphabet.
   function automatic logic [6:0] glyph_to_digit(input logic [7:0] ch);
      logic [6:0] v;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = {1'b0, 6'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         v = {1'b0, 6'(ch - 8'h41 + 8'd10)};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         v = {1'b0, 6'(ch - 8'h61 + 8'd36)};
      end else begin
         v = 7'h40;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/b62_div_step.sv -----
// ----------------------------------------------------------------------------
// b62_div_step: one radix-64 step of long division by 62.
// Takes the running remainder joined with the next 6-bit chunk and returns
// the quotient digit and the new remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module b62_div_step
   import b62_pkg::*;
(
   input  wire logic [11:0] partial,
   output logic [5:0]       quot_digit,
   output logic [5:0]       remainder
);

   // 1057 / 65536 is just below 1/62, so the estimate is low by at most one.
   localparam logic [10:0] RECIP = 11'd1057;

   logic [22:0] product;
   logic [5:0]  q_est;
   logic [11:0] r_est;

   always_comb begin
      product = {11'd0, partial} * {12'd0, RECIP};
      q_est   = product[21:16];
      r_est   = partial - 12'(BASE) * {6'd0, q_est};
      if (r_est >= 12'(BASE)) begin
         quot_digit = q_est + 6'd1;
         remainder  = 6'(r_est - 12'(BASE));
      end else begin
         quot_digit = q_est;
         remainder  = r_est[5:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/base62_codec_unit.sv -----
// ----------------------------------------------------------------------------
// base62_codec_unit: two-way base-62 codec (0-9, A-Z, a-z).
// Encode: all digits are worked out on the shared divide-by-62 step (one
// 6-bit chunk per cycle) before the first leaves, most significant first;
// an n-digit request (n up to 11) holds the input until its last digit has
// left, and output stalls add to this.
// Decode: each character passes S_DEC, and one that ends the code S_DRSP too.
// Synchronous reset clears the sequencer, the response valid flag and decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module base62_codec_unit
   import b62_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_EMIT = 5'b00100,
      S_DEC  = 5'b01000,
      S_DRSP = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [DIVD_W-1:0]       divd_ff, divd_in;
   logic [DIVD_W-1:0]       quot_ff, quot_in;
   logic [5:0]              rem_ff, rem_in;
   logic [CHUNK_CNT_W-1:0]  chunk_ff, chunk_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [7:0]              char_ff, char_in;
   logic                    end_ff, end_in;
   logic [NUM_W-1:0]        acc_ff, acc_in;
   logic [1:0]              err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [5:0]              digit_buf [MAX_DIGITS];

   logic [11:0]             partial;
   logic [5:0]              q_digit;
   logic [5:0]              r_digit;
   logic [DIVD_W-1:0]       quot_next;
   logic                    buf_we;
   logic                    slot_free;
   logic                    accept;
   logic [6:0]              dec_val;
   logic [NUM_W+5:0]        dec_sum;

   b62_div_step u_div_step (
      .partial    (partial),
      .quot_digit (q_digit),
      .remainder  (r_digit)
   );

   assign partial   = {rem_ff, divd_ff[DIVD_W-1 -: CHUNK_W]};
   assign quot_next = {quot_ff[DIVD_W-CHUNK_W-1:0], q_digit};
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // acc * 62 + d is {acc, d} - 2 * acc; any bit above 62 means overflow.
   assign dec_val = glyph_to_digit(char_ff);
   assign dec_sum = {acc_ff, dec_val[5:0]} - {5'd0, acc_ff, 1'b0};

   always_comb begin
      state_in     = state_ff;
      divd_in      = divd_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      end_in       = end_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      buf_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_ENCODE) begin
                  divd_in  = {{(DIVD_W-NUM_W){1'b0}}, req_data.number};
                  quot_in  = '0;
                  rem_in   = '0;
                  chunk_in = '0;
                  idx_in   = '0;
                  state_in = S_DIV;
               end else begin
                  char_in  = req_data.code_char;
                  end_in   = req_data.end_of_code;
                  state_in = S_DEC;
               end
            end
         end
         S_DIV: begin
            divd_in = divd_ff << CHUNK_W;
            quot_in = quot_next;
            rem_in  = r_digit;
            if (chunk_ff == CHUNK_CNT_W'(NUM_CHUNKS - 1)) begin
               // The remainder of the last chunk is the next digit.
               buf_we = 1'b1;
               if (quot_next == '0 || idx_ff == IDX_W'(MAX_DIGITS - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  divd_in  = quot_next;
                  quot_in  = '0;
                  rem_in   = '0;
                  chunk_in = '0;
                  idx_in   = idx_ff + IDX_W'(1);
               end
            end else begin
               chunk_in = chunk_ff + CHUNK_CNT_W'(1);
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.digit_char    = digit_to_glyph(digit_buf[idx_ff]);
               rsp_in.last_digit    = (idx_ff == '0);
               rsp_in.decoded_value = '0;
               rsp_in.status        = ST_OK;
               rsp_in.result_kind   = KIND_DIGIT;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         S_DEC: begin
            if (err_ff == ST_OK) begin
               if (dec_val[6]) begin
                  err_in = ST_BAD_CHAR;
               end else if (dec_sum[NUM_W+5:NUM_W] != '0) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  acc_in = dec_sum[NUM_W-1:0];
               end
            end
            state_in = end_ff ? S_DRSP : S_IDLE;
         end
         S_DRSP: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.digit_char    = '0;
               rsp_in.last_digit    = 1'b0;
               rsp_in.decoded_value = (err_ff == ST_OK) ? acc_ff : '0;
               rsp_in.status        = err_ff;
               rsp_in.result_kind   = KIND_DECODE;
               acc_in               = '0;
               err_in               = ST_OK;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= ST_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      divd_ff  <= divd_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      chunk_ff <= chunk_in;
      idx_ff   <= idx_in;
      char_ff  <= char_in;
      end_ff   <= end_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         digit_buf[idx_ff] <= r_digit;
      end
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base-62 encoder/decoder.
// A short list of directed requests (zero, one-digit and full-width numbers,
// boundary glyphs, bad bytes, sticky errors, overflow, encodes in the middle
// of a code) is followed by random encodes and random codes, some of them
// broken. Both handshake sides idle at random. Every response is compared
// with a private model of the codec, or with a hand-written value.
// ----------------------------------------------------------------------------
module tb_top
   import b62_pkg::*;
();

   localparam int unsigned ITEMS       = 310;
   localparam int unsigned PAUSE_AT    = 160;
   localparam int unsigned DRAIN_WAIT  = 300;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [62:0] NUM_MAX     = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam string GLYPHS =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

   typedef struct packed {
      req_type rq;
      logic    typed;
      rsp_type want;
   } step_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Private copy of the decode state.
   logic [62:0] code_acc = '0;
   logic [1:0]  code_err = ST_OK;

   rsp_type      step_results[$];
   rsp_type      due_results[$];
   step_row_type dir_rows[$];
   int unsigned  accepted    = 0;
   int           errors      = 0;
   int unsigned  cycle_count = 0;
   int unsigned  stall_left  = 0;
   bit           send_quiet  = 1'b0;
   bit           recv_quiet  = 1'b0;

   base62_codec_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int glyph_index(input logic [7:0] ch);
      for (int i = 0; i < 62; i++) begin
         if (GLYPHS[i] == ch) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Fills step_results with what one request produces and updates the decode state.
   function automatic void compute_codec_results(input req_type r);
      logic [62:0] n;
      logic [5:0]  digs [11];
      logic [63:0] lim;
      rsp_type     e;
      int          cnt;
      int          v;
      step_results.delete();
      if (r.operation == OP_ENCODE) begin
         n   = r.number;
         cnt = 0;
         do begin
            digs[cnt] = 6'(n % 63'd62);
            n         = n / 63'd62;
            cnt++;
         end while (n != 0 && cnt < 11);
         for (int k = cnt - 1; k >= 0; k--) begin
            e               = '0;
            e.digit_char    = GLYPHS[digs[k]];
            e.last_digit    = (k == 0);
            e.result_kind   = KIND_DIGIT;
            step_results.insert(step_results.size(), e);
         end
      end else begin
         if (code_err == ST_OK) begin
            v = glyph_index(r.code_char);
            if (v < 0) begin
               code_err = ST_BAD_CHAR;
            end else begin
               lim = (64'h7FFF_FFFF_FFFF_FFFF - 64'(v)) / 64'd62;
               if ({1'b0, code_acc} > lim) begin
                  code_err = ST_OVERFLOW;
               end else begin
                  code_acc = 63'(code_acc * 63'd62 + 63'(v));
               end
            end
         end
         if (r.end_of_code) begin
            e               = '0;
            e.decoded_value = (code_err == ST_OK) ? code_acc : '0;
            e.status        = code_err;
            e.result_kind   = KIND_DECODE;
            step_results.insert(step_results.size(), e);
            code_acc = '0;
            code_err = ST_OK;
         end
      end
   endfunction

   // Mostly short gaps, a few long ones; none at all while quiet.
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Unused fields carry random bits; the block must ignore them.
   function automatic req_type enc(input logic [62:0] n);
      req_type r;
      r.operation   = OP_ENCODE;
      r.number      = n;
      r.code_char   = 8'($urandom);
      r.end_of_code = 1'($urandom);
      return r;
   endfunction

   function automatic req_type dec(input logic [7:0] ch, input logic last);
      req_type r;
      r.operation   = OP_DECODE;
      r.number      = 63'({$urandom, $urandom});
      r.code_char   = ch;
      r.end_of_code = last;
      return r;
   endfunction

   function automatic rsp_type digit_rsp(input logic [7:0] ch);
      return {ch, 1'b1, 63'd0, ST_OK, KIND_DIGIT};
   endfunction

   function automatic rsp_type decode_rsp(input logic [62:0] val, input logic [1:0] st);
      return {8'h00, 1'b0, val, st, KIND_DECODE};
   endfunction

   function automatic void add_row(input req_type rq, input logic typed,
                                   input rsp_type want);
      step_row_type row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic logic [62:0] rand_number();
      logic [62:0] p;
      int          k;
      case ($urandom_range(0, 3))
         0: begin
            // Powers of 62 and one below them hit every digit-count boundary.
            p = 63'd1;
            k = $urandom_range(0, 10);
            repeat (k) p = p * 63'd62;
            return p - 63'($urandom_range(0, 1));
         end
         1: return 63'({$urandom, $urandom});
         2: return 63'({$urandom, $urandom}) >> $urandom_range(0, 62);
         default: return 63'($urandom_range(0, 4000));
      endcase
   endfunction

   task automatic issue(input req_type r, input logic typed, input rsp_type want);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      compute_codec_results(r);
      if (typed) begin
         due_results.insert(due_results.size(), want);
      end else begin
         foreach (step_results[i]) due_results.insert(due_results.size(), step_results[i]);
      end
      accepted++;
      gap = pick_gap(send_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Never returns without waiting on the clock, so the next request drives valid later.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic check_field(input string what, input logic [62:0] want,
                              input logic [62:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type     want;
      int unsigned len;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: response with nothing expected, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("digit_char", 63'(want.digit_char), 63'(rsp_data.digit_char));
            check_field("last_digit", 63'(want.last_digit), 63'(rsp_data.last_digit));
            check_field("decoded_value", want.decoded_value, rsp_data.decoded_value);
            check_field("status", 63'(want.status), 63'(rsp_data.status));
            check_field("result_kind", 63'(want.result_kind), 63'(rsp_data.result_kind));
         end
      end
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         if ($urandom_range(0, 199) == 0) begin
            recv_quiet = ~recv_quiet;
         end
         len = pick_gap(recv_quiet);
         rsp_stall  <= (len != 0);
         stall_left <= (len == 0) ? 0 : len - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned len;
      int unsigned pick;
      bit          paused;
      logic [7:0]  ch;
      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(enc(63'd0), 1'b1, digit_rsp(8'h30));
      add_row(enc(63'd61), 1'b1, digit_rsp(8'h7A));
      add_row(enc(63'd62), 1'b0, rsp_type'('0));
      add_row(enc(NUM_MAX), 1'b0, rsp_type'('0));
      add_row(dec(8'h7A, 1'b1), 1'b1, decode_rsp(63'd61, ST_OK));
      add_row(dec(8'h00, 1'b1), 1'b1, decode_rsp(63'd0, ST_BAD_CHAR));
      add_row(dec(8'hFF, 1'b1), 1'b1, decode_rsp(63'd0, ST_BAD_CHAR));
      // A bad byte early in a code wins over the good ones after it.
      add_row(dec(8'h21, 1'b0), 1'b0, rsp_type'('0));
      add_row(dec(8'h41, 1'b1), 1'b1, decode_rsp(63'd0, ST_BAD_CHAR));
      // An encode in the middle of a code leaves the code's state alone.
      add_row(dec(8'h31, 1'b0), 1'b0, rsp_type'('0));
      add_row(enc(63'd5), 1'b1, digit_rsp(8'h35));
      add_row(dec(8'h30, 1'b1), 1'b1, decode_rsp(63'd62, ST_OK));
      // "Bzzzzzzzzzz" passes the signed 64-bit maximum on its last glyph.
      add_row(dec(8'h42, 1'b0), 1'b0, rsp_type'('0));
      repeat (9) add_row(dec(8'h7A, 1'b0), 1'b0, rsp_type'('0));
      add_row(dec(8'h7A, 1'b1), 1'b1, decode_rsp(63'd0, ST_OVERFLOW));

      foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

      while (accepted < ITEMS) begin
         if (!paused && accepted >= PAUSE_AT) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 29) == 0) begin
            send_quiet = ~send_quiet;
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            issue(enc(rand_number()), 1'b0, '0);
         end else if (pick < 9) begin
            pick = $urandom_range(0, 9);
            len  = (pick < 6) ? $urandom_range(1, 6) :
                   (pick < 8) ? $urandom_range(7, 10) : $urandom_range(11, 13);
            for (int unsigned i = 0; i < len; i++) begin
               if ($urandom_range(0, 15) == 0) begin
                  ch = 8'($urandom);
               end else begin
                  ch = GLYPHS[$urandom_range(0, 61)];
               end
               issue(dec(ch, i == len - 1), 1'b0, '0);
               if (i != len - 1 && $urandom_range(0, 9) == 0) begin
                  issue(enc(rand_number()), 1'b0, '0);
               end
            end
         end else begin
            issue(dec(8'($urandom), 1'($urandom)), 1'b0, '0);
         end
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, due_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/b62_pkg.sv
rtl/core/b62_div_step.sv
rtl/core/base62_codec_unit.sv
tb/tb_top.sv
